>>> rtl/core/mcg_pkg.sv
// Shared types and constants for the midpoint circle generator.
// No dependencies; used by every module under rtl/core.
package mcg_pkg;

    // Widths of the datapath
    localparam int COORD_BITS     = 16;
    localparam int OFF_BITS       = 13;
    localparam int DEC_BITS       = 16;
    localparam int IN_COORD_BITS  = 15;
    localparam int RADIUS_BITS    = 12;
    localparam int COLOR_BITS     = 32;
    localparam int CLIP_POS_BITS  = 12;
    localparam int CLIP_SIZE_BITS = 13;
    localparam int CLIP_END_BITS  = 14;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int POINT_BITS     = 3;

    // Item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Decision update constants
    localparam logic [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_DIAG = DEC_BITS'(10);
    localparam logic [DEC_BITS-1:0] DEC_AXIS = DEC_BITS'(6);

    // Last point of an octet
    localparam logic [POINT_BITS-1:0] POINT_LAST = '1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_WIDTH  = 2'd2,
        REG_CLIP_HEIGHT = 2'd3
    } cfg_reg_t;

    // One octet to emit: offsets, centre, colour and the final-step flag
    typedef struct packed {
        logic [OFF_BITS-1:0]   off_x;
        logic [OFF_BITS-1:0]   off_y;
        logic [COORD_BITS-1:0] centre_col;
        logic [COORD_BITS-1:0] centre_row;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } octet_t;

endpackage

>>> rtl/core/mcg_stepper.sv
// Circle state and midpoint step: loads a circle on start, advances on step.
// Depends on mcg_pkg.
module mcg_stepper (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_take,
    input  logic                                   func,
    input  logic signed [mcg_pkg::IN_COORD_BITS-1:0] center_x,
    input  logic signed [mcg_pkg::IN_COORD_BITS-1:0] center_y,
    input  logic [mcg_pkg::RADIUS_BITS-1:0]        radius,
    input  logic [mcg_pkg::COLOR_BITS-1:0]         color,
    output logic                                   octet_load,
    output mcg_pkg::octet_t                        octet
);

    logic [mcg_pkg::OFF_BITS-1:0]   off_x_reg, off_x_next;
    logic [mcg_pkg::OFF_BITS-1:0]   off_y_reg, off_y_next;
    logic [mcg_pkg::DEC_BITS-1:0]   dec_reg, dec_next;
    logic [mcg_pkg::COORD_BITS-1:0] col_reg, col_next;
    logic [mcg_pkg::COORD_BITS-1:0] row_reg, row_next;
    logic [mcg_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                           active_reg, active_next;

    logic [mcg_pkg::OFF_BITS:0]     x1;
    logic [mcg_pkg::OFF_BITS:0]     y1;
    logic [mcg_pkg::DEC_BITS-1:0]   diff;
    logic [mcg_pkg::DEC_BITS-1:0]   dec_adv;
    logic                           dec_pos;
    logic                           done;

    // Midpoint advance: x+1, y-1 when the decision is positive
    always_comb
    begin
        dec_pos = ($signed(dec_reg) > $signed(mcg_pkg::DEC_BITS'(0)));
        x1 = {off_x_reg[mcg_pkg::OFF_BITS-1], off_x_reg} + (mcg_pkg::OFF_BITS+1)'(1);
        if (dec_pos)
        begin
            y1 = {off_y_reg[mcg_pkg::OFF_BITS-1], off_y_reg} - (mcg_pkg::OFF_BITS+1)'(1);
            diff = mcg_pkg::DEC_BITS'($signed(x1)) - mcg_pkg::DEC_BITS'($signed(y1));
            dec_adv = dec_reg + (diff << 2) + mcg_pkg::DEC_DIAG;
        end
        else
        begin
            y1 = {off_y_reg[mcg_pkg::OFF_BITS-1], off_y_reg};
            diff = mcg_pkg::DEC_BITS'($signed(x1));
            dec_adv = dec_reg + (diff << 2) + mcg_pkg::DEC_AXIS;
        end
        done = ($signed(y1) < $signed(x1));
    end

    assign octet_load = item_take && (func == mcg_pkg::FUNC_STEP) && active_reg;

    // Octet snapshot taken before the advance
    always_comb
    begin
        octet.off_x      = off_x_reg;
        octet.off_y      = off_y_reg;
        octet.centre_col = col_reg;
        octet.centre_row = row_reg;
        octet.color      = color_reg;
        octet.done       = done;
    end

    // Next state
    always_comb
    begin
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        dec_next    = dec_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        color_next  = color_reg;
        active_next = active_reg;
        if (item_take && (func == mcg_pkg::FUNC_START))
        begin
            off_x_next  = '0;
            off_y_next  = {1'b0, radius};
            dec_next    = mcg_pkg::DEC_INIT - {{(mcg_pkg::DEC_BITS-mcg_pkg::RADIUS_BITS-1){1'b0}},
                                               radius, 1'b0};
            col_next    = mcg_pkg::COORD_BITS'(center_x);
            row_next    = mcg_pkg::COORD_BITS'(center_y);
            color_next  = color;
            active_next = 1'b1;
        end
        else if (octet_load)
        begin
            off_x_next = x1[mcg_pkg::OFF_BITS-1:0];
            off_y_next = y1[mcg_pkg::OFF_BITS-1:0];
            dec_next   = dec_adv;
            if (done)
            begin
                active_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            dec_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            off_x_reg  <= off_x_next;
            off_y_reg  <= off_y_next;
            dec_reg    <= dec_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

endmodule

>>> rtl/core/mcg_emitter.sv
// Octet emitter: walks the eight mirrored points, clips them and drives the
// result register. Holds the clip window registers. Depends on mcg_pkg.
module mcg_emitter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mcg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mcg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  octet_load,
    input  mcg_pkg::octet_t                       octet,
    output logic                                  octet_ready,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mcg_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [mcg_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                  visible,
    output logic [mcg_pkg::COLOR_BITS-1:0]        pixel_color,
    output logic                                  last,
    output logic                                  arc_done
);

    logic [mcg_pkg::CLIP_POS_BITS-1:0]  left_reg, top_reg;
    logic [mcg_pkg::CLIP_SIZE_BITS-1:0] width_reg, height_reg;

    mcg_pkg::octet_t                    oct_reg;
    logic                               oct_valid_reg, oct_valid_next;
    logic [mcg_pkg::POINT_BITS-1:0]     pt_reg, pt_next;

    logic                               out_valid_reg;
    logic [mcg_pkg::COORD_BITS-1:0]     px_reg, py_reg;
    logic                               vis_reg;
    logic [mcg_pkg::COLOR_BITS-1:0]     color_reg;
    logic                               last_reg, done_reg;

    logic                               out_adv;
    logic                               emit;
    logic                               pt_last;
    logic [mcg_pkg::OFF_BITS-1:0]       a, b;
    logic [mcg_pkg::COORD_BITS-1:0]     a_ext, b_ext, dx, dy, px, py;
    logic [mcg_pkg::CLIP_END_BITS-1:0]  right, bottom;
    logic                               vis;

    // Clip window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (mcg_pkg::cfg_reg_t'(cfg_index))
                mcg_pkg::REG_CLIP_LEFT:   left_reg   <= cfg_data[mcg_pkg::CLIP_POS_BITS-1:0];
                mcg_pkg::REG_CLIP_TOP:    top_reg    <= cfg_data[mcg_pkg::CLIP_POS_BITS-1:0];
                mcg_pkg::REG_CLIP_WIDTH:  width_reg  <= cfg_data;
                mcg_pkg::REG_CLIP_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake between octet slot and result register
    assign out_adv     = !out_valid_reg || !out_stall;
    assign emit        = oct_valid_reg && out_adv;
    assign pt_last     = (pt_reg == mcg_pkg::POINT_LAST);
    assign octet_ready = !oct_valid_reg || (emit && pt_last);

    // Point order: bit 2 swaps axes, bit 0 negates column, bit 1 negates row
    always_comb
    begin
        a      = pt_reg[2] ? oct_reg.off_y : oct_reg.off_x;
        b      = pt_reg[2] ? oct_reg.off_x : oct_reg.off_y;
        a_ext  = mcg_pkg::COORD_BITS'($signed(a));
        b_ext  = mcg_pkg::COORD_BITS'($signed(b));
        dx     = pt_reg[0] ? -a_ext : a_ext;
        dy     = pt_reg[1] ? -b_ext : b_ext;
        px     = oct_reg.centre_col + dx;
        py     = oct_reg.centre_row + dy;
        right  = {2'b00, left_reg} + {1'b0, width_reg};
        bottom = {2'b00, top_reg} + {1'b0, height_reg};
        vis    = ($signed(px) >= $signed({4'b0000, left_reg}))
              && ($signed({{2{px[mcg_pkg::COORD_BITS-1]}}, px}) < $signed({4'b0000, right}))
              && ($signed(py) >= $signed({4'b0000, top_reg}))
              && ($signed({{2{py[mcg_pkg::COORD_BITS-1]}}, py}) < $signed({4'b0000, bottom}));
    end

    // Octet slot sequencing
    always_comb
    begin
        oct_valid_next = oct_valid_reg;
        pt_next        = pt_reg;
        if (emit)
        begin
            pt_next = pt_reg + mcg_pkg::POINT_BITS'(1);
            if (pt_last)
            begin
                oct_valid_next = 1'b0;
            end
        end
        if (octet_load)
        begin
            oct_valid_next = 1'b1;
            pt_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_valid_reg <= 1'b0;
            pt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            oct_valid_reg <= oct_valid_next;
            pt_reg        <= pt_next;
            if (out_adv)
            begin
                out_valid_reg <= oct_valid_reg;
            end
        end
    end

    // Octet and result payload
    always_ff @(posedge clk)
    begin
        if (octet_load)
        begin
            oct_reg <= octet;
        end
        if (emit)
        begin
            px_reg    <= px;
            py_reg    <= py;
            vis_reg   <= vis;
            color_reg <= oct_reg.color;
            last_reg  <= pt_last;
            done_reg  <= pt_last && oct_reg.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign visible     = vis_reg;
    assign pixel_color = color_reg;
    assign last        = last_reg;
    assign arc_done    = done_reg;

endmodule

>>> rtl/core/midpoint_circle_generator_top.sv
// Top level of the midpoint circle generator.
// Depends on mcg_pkg, mcg_stepper and mcg_emitter.
//
// Usage:
//   Input channel (in_valid/in_stall) carries items. func = start loads the
//   centre, radius and colour and yields no point. func = step yields the
//   eight mirrored points of the current octet, then advances the circle.
//   A step with no circle running is taken and dropped.
//   Output channel (out_valid/out_stall) carries one point per transfer; the
//   eighth has last set, and arc_done as well on the circle's final step.
//   Clip window registers are written through cfg_we/cfg_index/cfg_data.
// Pipeline: a taken step is held in the octet slot register, and each point
//   passes through the result register before it reaches the outputs.
// Throughput: one point per cycle while out_stall is low; a step holds the
//   octet slot until its eighth point is emitted. Items of either kind are
//   taken whenever the slot is free or about to empty.
// Reset: rst_n clears the circle (idle), clip window and both valid flags.
// Stall: out_stall holds the result register; the octet walk pauses and
//   in_stall rises once the octet slot is occupied.
module midpoint_circle_generator_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mcg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [mcg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    func,
    input  logic signed [mcg_pkg::IN_COORD_BITS-1:0] center_x,
    input  logic signed [mcg_pkg::IN_COORD_BITS-1:0] center_y,
    input  logic [mcg_pkg::RADIUS_BITS-1:0]         radius,
    input  logic [mcg_pkg::COLOR_BITS-1:0]          color,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [mcg_pkg::COORD_BITS-1:0]   pixel_x,
    output logic signed [mcg_pkg::COORD_BITS-1:0]   pixel_y,
    output logic                                    visible,
    output logic [mcg_pkg::COLOR_BITS-1:0]          pixel_color,
    output logic                                    last,
    output logic                                    arc_done
);

    logic            octet_ready;
    logic            octet_load;
    logic            item_take;
    mcg_pkg::octet_t octet;

    // Input handshake
    assign in_stall  = !octet_ready;
    assign item_take = in_valid && octet_ready;

    mcg_stepper u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_take  (item_take),
        .func       (func),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .color      (color),
        .octet_load (octet_load),
        .octet      (octet)
    );

    mcg_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .octet_load  (octet_load),
        .octet       (octet),
        .octet_ready (octet_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .visible     (visible),
        .pixel_color (pixel_color),
        .last        (last),
        .arc_done    (arc_done)
    );

endmodule
